[hdl/fpfa_pkg.sv]
// ----------------------------------------------------------------------------
// Fixed-partition fit allocator package
// Shared constants, operation codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package fpfa_pkg;

  localparam int unsigned MAX_PARTITIONS_DEF = 16;
  localparam int unsigned SIZE_WIDTH_DEF     = 16;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned AMOUNT_W = 16;
  localparam int unsigned PIU_W    = 5;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned APB_AW   = 3;

  localparam logic [OP_W-1:0] OP_LOAD     = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOCATE = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTORE  = 2'd2;

  localparam logic REG_FIT_MODE          = 1'b0;
  localparam logic REG_PARTITIONS_IN_USE = 1'b1;

  localparam logic [PIU_W-1:0] PIU_RESET = 5'd16;

  typedef struct packed {
    logic capture;
    logic load_wr;
    logic sweep;
    logic scan;
    logic commit;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic issue_done;
    logic rd_vld;
    logic out_busy;
  } dp_status_t;

endpackage

[hdl/fpfa_ctrl.sv]
// ----------------------------------------------------------------------------
// Fixed-partition fit allocator controller
// One-hot state machine that sequences load, restore sweep and allocate scan.
// ----------------------------------------------------------------------------
module fpfa_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [fpfa_pkg::OP_W-1:0]         operation_i,
  input  fpfa_pkg::dp_status_t              status_i,
  output fpfa_pkg::ctrl_cmd_t               cmd_o
);
  import fpfa_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_LOAD   = 6'b000010,
    S_SWEEP  = 6'b000100,
    S_SCAN   = 6'b001000,
    S_COMMIT = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          case (operation_i)
            OP_LOAD:     state_d = S_LOAD;
            OP_ALLOCATE: state_d = S_SCAN;
            OP_RESTORE:  state_d = S_SWEEP;
            default:     state_d = S_DONE;
          endcase
        end
      end
      S_LOAD: begin
        cmd_o.load_wr = 1'b1;
        state_d       = S_DONE;
      end
      S_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (status_i.issue_done && !status_i.rd_vld) begin
          state_d = S_DONE;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.issue_done && !status_i.rd_vld) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

[hdl/fpfa_datapath.sv]
// ----------------------------------------------------------------------------
// Fixed-partition fit allocator datapath
// Partition memories, taken marks, scan evaluation and the result register.
// ----------------------------------------------------------------------------
module fpfa_datapath #(
  parameter int unsigned MAX_PARTITIONS = fpfa_pkg::MAX_PARTITIONS_DEF,
  parameter int unsigned SIZE_WIDTH     = fpfa_pkg::SIZE_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fpfa_pkg::ctrl_cmd_t               cmd_i,
  output fpfa_pkg::dp_status_t              status_o,
  input  logic [fpfa_pkg::OP_W-1:0]         operation_i,
  input  logic [fpfa_pkg::SLOT_W-1:0]       slot_index_i,
  input  logic [fpfa_pkg::AMOUNT_W-1:0]     amount_i,
  input  logic                              fit_mode_i,
  input  logic [fpfa_pkg::PIU_W-1:0]        partitions_in_use_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              granted_o,
  output logic [fpfa_pkg::SLOT_W-1:0]       chosen_slot_o,
  output logic [fpfa_pkg::AMOUNT_W-1:0]     space_before_o,
  output logic [fpfa_pkg::AMOUNT_W-1:0]     space_after_o
);
  import fpfa_pkg::*;

  localparam int unsigned IDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_PARTITIONS + 1);

  logic [SIZE_WIDTH-1:0] cur_mem  [MAX_PARTITIONS];
  logic [SIZE_WIDTH-1:0] orig_mem [MAX_PARTITIONS];
  logic [MAX_PARTITIONS-1:0] taken_q;

  logic [SLOT_W-1:0]     req_slot_q;
  logic [SIZE_WIDTH-1:0] req_amt_q;
  logic [CNT_W-1:0]      ptr_q, lim_q, lim_d;

  logic                  rd_vld_q;
  logic [IDX_W-1:0]      rd_idx_q;
  logic [SIZE_WIDTH-1:0] cur_rd_q, orig_rd_q;
  logic                  taken_rd_q;

  logic                  found_q;
  logic [IDX_W-1:0]      best_idx_q;
  logic [SIZE_WIDTH-1:0] best_before_q, best_left_q;

  logic                  res_granted_q;
  logic [SLOT_W-1:0]     res_slot_q;
  logic [AMOUNT_W-1:0]   res_before_q, res_after_q;

  logic                  out_valid_q;
  logic                  out_granted_q;
  logic [SLOT_W-1:0]     out_slot_q;
  logic [AMOUNT_W-1:0]   out_before_q, out_after_q;

  logic                  issue_done, rd_en, slot_ok, fit, take;
  logic [SIZE_WIDTH-1:0] left;
  logic                  cur_we;
  logic [IDX_W-1:0]      cur_wa, slot_idx;
  logic [SIZE_WIDTH-1:0] cur_wd;

  assign issue_done = (ptr_q == lim_q);
  assign rd_en      = (cmd_i.scan || cmd_i.sweep) && !issue_done;
  assign slot_ok    = (32'(req_slot_q) < MAX_PARTITIONS);
  assign slot_idx   = IDX_W'(req_slot_q);

  assign fit  = !taken_rd_q && (cur_rd_q >= req_amt_q);
  assign left = cur_rd_q - req_amt_q;
  assign take = cmd_i.scan && rd_vld_q && fit &&
                (!found_q || (fit_mode_i && (left < best_left_q)));

  always_comb begin
    if (operation_i == OP_RESTORE) begin
      lim_d = CNT_W'(MAX_PARTITIONS);
    end else if (32'(partitions_in_use_i) > MAX_PARTITIONS) begin
      lim_d = CNT_W'(MAX_PARTITIONS);
    end else begin
      lim_d = CNT_W'(partitions_in_use_i);
    end
  end

  always_comb begin
    cur_we = 1'b0;
    cur_wa = rd_idx_q;
    cur_wd = orig_rd_q;
    if (cmd_i.load_wr) begin
      cur_we = slot_ok;
      cur_wa = slot_idx;
      cur_wd = req_amt_q;
    end else if (cmd_i.sweep) begin
      cur_we = rd_vld_q;
    end else if (cmd_i.commit) begin
      cur_we = found_q;
      cur_wa = best_idx_q;
      cur_wd = best_left_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cur_we) begin
      cur_mem[cur_wa] <= cur_wd;
    end
    if (cmd_i.load_wr && slot_ok) begin
      orig_mem[slot_idx] <= req_amt_q;
    end
    if (rd_en) begin
      cur_rd_q  <= cur_mem[ptr_q[IDX_W-1:0]];
      orig_rd_q <= orig_mem[ptr_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_idx_q   <= ptr_q[IDX_W-1:0];
      taken_rd_q <= taken_q[ptr_q[IDX_W-1:0]];
    end
    if (cmd_i.capture) begin
      req_slot_q <= slot_index_i;
      req_amt_q  <= SIZE_WIDTH'(amount_i);
    end
    if (take) begin
      best_idx_q    <= rd_idx_q;
      best_before_q <= cur_rd_q;
      best_left_q   <= left;
    end
    if (cmd_i.capture) begin
      res_granted_q <= 1'b0;
      res_slot_q    <= '0;
      res_before_q  <= '0;
      res_after_q   <= '0;
    end else if (cmd_i.commit && found_q) begin
      res_granted_q <= 1'b1;
      res_slot_q    <= SLOT_W'(best_idx_q);
      res_before_q  <= AMOUNT_W'(best_before_q);
      res_after_q   <= AMOUNT_W'(best_left_q);
    end
    if (cmd_i.out_load) begin
      out_granted_q <= res_granted_q;
      out_slot_q    <= res_slot_q;
      out_before_q  <= res_before_q;
      out_after_q   <= res_after_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q     <= '0;
      ptr_q       <= '0;
      lim_q       <= '0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q <= rd_en;
      if (cmd_i.capture) begin
        ptr_q   <= '0;
        lim_q   <= lim_d;
        found_q <= 1'b0;
        if (operation_i == OP_RESTORE) begin
          taken_q <= '0;
        end
      end else begin
        if (rd_en) begin
          ptr_q <= ptr_q + CNT_W'(1);
        end
        if (take) begin
          found_q <= 1'b1;
        end
        if (cmd_i.load_wr && slot_ok) begin
          taken_q[slot_idx] <= 1'b0;
        end
        if (cmd_i.commit && found_q) begin
          taken_q[best_idx_q] <= 1'b1;
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.issue_done = issue_done;
  assign status_o.rd_vld     = rd_vld_q;
  assign status_o.out_busy   = out_valid_q && out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign granted_o      = out_granted_q;
  assign chosen_slot_o  = out_slot_q;
  assign space_before_o = out_before_q;
  assign space_after_o  = out_after_q;

endmodule

[hdl/fixed_partition_fit_allocator.sv]
// ----------------------------------------------------------------------------
// Fixed-partition fit allocator
// First-fit or best-fit allocation over a set of fixed memory partitions.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake               Payload
//  in       input      in_valid_i/in_stall_o   operation, slot_index, amount
//  out      output     out_valid_o/out_stall_i granted, chosen_slot, space_*
//  cfg      input      APB psel/penable        fit_mode, partitions_in_use
//
// A load writes the addressed partition and an unused code goes straight to
// the result. An allocate scans the first n partitions, n being the scan limit,
// with a one-entry-per-cycle read of the partition memory, then commits. A
// restore sweeps all MAX_PARTITIONS entries, one memory copy per cycle. No
// clearing pass follows reset.
// A stalled result holds the block after its work is done; a new request is
// taken once that result has moved into the output register.
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator #(
  parameter int unsigned MAX_PARTITIONS = fpfa_pkg::MAX_PARTITIONS_DEF,
  parameter int unsigned SIZE_WIDTH     = fpfa_pkg::SIZE_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fpfa_pkg::APB_AW-1:0]       paddr,
  input  logic [fpfa_pkg::APB_DW-1:0]       pwdata,
  output logic [fpfa_pkg::APB_DW-1:0]       prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [fpfa_pkg::OP_W-1:0]         operation_i,
  input  logic [fpfa_pkg::SLOT_W-1:0]       slot_index_i,
  input  logic [fpfa_pkg::AMOUNT_W-1:0]     amount_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              granted_o,
  output logic [fpfa_pkg::SLOT_W-1:0]       chosen_slot_o,
  output logic [fpfa_pkg::AMOUNT_W-1:0]     space_before_o,
  output logic [fpfa_pkg::AMOUNT_W-1:0]     space_after_o
);
  import fpfa_pkg::*;

  logic              fit_mode_q;
  logic [PIU_W-1:0]  piu_q;
  logic              cfg_wr;
  ctrl_cmd_t         cmd;
  dp_status_t        status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q <= 1'b0;
      piu_q      <= PIU_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_FIT_MODE:          fit_mode_q <= pwdata[0];
        REG_PARTITIONS_IN_USE: piu_q      <= pwdata[PIU_W-1:0];
        default:               fit_mode_q <= fit_mode_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FIT_MODE:          prdata = APB_DW'(fit_mode_q);
      REG_PARTITIONS_IN_USE: prdata = APB_DW'(piu_q);
      default:               prdata = '0;
    endcase
  end

  fpfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  fpfa_datapath #(
    .MAX_PARTITIONS (MAX_PARTITIONS),
    .SIZE_WIDTH     (SIZE_WIDTH)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .operation_i         (operation_i),
    .slot_index_i        (slot_index_i),
    .amount_i            (amount_i),
    .fit_mode_i          (fit_mode_q),
    .partitions_in_use_i (piu_q),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .granted_o           (granted_o),
    .chosen_slot_o       (chosen_slot_o),
    .space_before_o      (space_before_o),
    .space_after_o       (space_after_o)
  );

endmodule
